### hdl/rlf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlf_pkg
// Shared widths, command and activity codes, and the lane control word of
// the RGB LED fade and flash engine.
// ----------------------------------------------------------------------------
package rlf_pkg;

    localparam int CMD_W   = 2;
    localparam int COL_W   = 8;
    localparam int CNT_W   = 8;
    localparam int PAUSE_W = 16;
    localparam int PWM_W   = 10;
    localparam int LANES   = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_SET   = 2'd1,
        CMD_RAMP  = 2'd2,
        CMD_BLINK = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ACT_IDLE  = 2'd0,
        ACT_FADE  = 2'd1,
        ACT_FLASH = 2'd2
    } t_act;

    typedef enum logic [2:0] {
        SRC_KEEP   = 3'd0,
        SRC_COL    = 3'd1,
        SRC_STEP   = 3'd2,
        SRC_SAVED  = 3'd3,
        SRC_TARGET = 3'd4
    } t_shown_src;

    typedef struct packed {
        t_shown_src shown_src;
        logic       load_target;
        logic       save_shown;
        logic       goal_col;
    } t_lane_ctl;

endpackage

### hdl/rlf_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlf_in_if / rlf_out_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface rlf_in_if;
    logic                        valid;
    logic                        ready;
    logic [rlf_pkg::CMD_W-1:0]   cmd;
    logic [rlf_pkg::COL_W-1:0]   red;
    logic [rlf_pkg::COL_W-1:0]   green;
    logic [rlf_pkg::COL_W-1:0]   blue;
    logic [rlf_pkg::CNT_W-1:0]   flash_count;
    logic [rlf_pkg::PAUSE_W-1:0] pause_ticks;

    modport source (output valid, cmd, red, green, blue, flash_count, pause_ticks,
                    input ready);
    modport sink (input valid, cmd, red, green, blue, flash_count, pause_ticks,
                  output ready);
endinterface

interface rlf_out_if;
    logic                      valid;
    logic                      ready;
    logic [rlf_pkg::PWM_W-1:0] pwm_red;
    logic [rlf_pkg::PWM_W-1:0] pwm_green;
    logic [rlf_pkg::PWM_W-1:0] pwm_blue;
    logic [rlf_pkg::COL_W-1:0] shown_red;
    logic [rlf_pkg::COL_W-1:0] shown_green;
    logic [rlf_pkg::COL_W-1:0] shown_blue;
    logic                      busy_res;

    modport source (output valid, pwm_red, pwm_green, pwm_blue, shown_red, shown_green,
                    shown_blue, busy_res, input ready);
    modport sink (input valid, pwm_red, pwm_green, pwm_blue, shown_red, shown_green,
                  shown_blue, busy_res, output ready);
endinterface

### hdl/rlf_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlf_lane
// One color channel: shown, target and saved values, and the one-unit
// fade step toward the goal.
// ----------------------------------------------------------------------------
module rlf_lane (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rlf_pkg::t_lane_ctl        i_ctl,
    input  logic [rlf_pkg::COL_W-1:0] i_col,
    output logic [rlf_pkg::COL_W-1:0] o_shown_nx,
    output logic                      o_eq_step
);

    logic [rlf_pkg::COL_W-1:0] r_shown;
    logic [rlf_pkg::COL_W-1:0] r_target;
    logic [rlf_pkg::COL_W-1:0] r_saved;
    logic [rlf_pkg::COL_W-1:0] w_goal;
    logic [rlf_pkg::COL_W-1:0] w_step;
    logic [rlf_pkg::COL_W-1:0] n_shown;

    assign w_goal = i_ctl.goal_col ? i_col : r_target;

    always_comb begin
        if (r_shown < w_goal) begin
            w_step = r_shown + 1'b1;
        end else if (r_shown > w_goal) begin
            w_step = r_shown - 1'b1;
        end else begin
            w_step = r_shown;
        end
    end

    assign o_eq_step = (w_step == w_goal);

    always_comb begin
        case (i_ctl.shown_src)
            rlf_pkg::SRC_COL:    n_shown = i_col;
            rlf_pkg::SRC_STEP:   n_shown = w_step;
            rlf_pkg::SRC_SAVED:  n_shown = r_saved;
            rlf_pkg::SRC_TARGET: n_shown = r_target;
            default:             n_shown = r_shown;
        endcase
    end

    assign o_shown_nx = n_shown;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown  <= '0;
            r_target <= '0;
            r_saved  <= '0;
        end else begin
            r_shown <= n_shown;
            if (i_ctl.load_target) begin
                r_target <= i_col;
            end
            // save the color shown before this word
            if (i_ctl.save_shown) begin
                r_saved <= r_shown;
            end
        end
    end

endmodule

### hdl/rlf_duty.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlf_duty
// Inverted CIE lightness lookup: channel value c gives duty lum(top - c),
// built as a constant table at elaboration with exact integer rounding.
// ----------------------------------------------------------------------------
module rlf_duty #(
    parameter int PWM_BITS = 10,
    parameter int LEVELS   = 256
) (
    input  logic [rlf_pkg::COL_W-1:0] i_c,
    output logic [rlf_pkg::PWM_W-1:0] o_duty
);

    localparam int IW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam logic [63:0] TOP  = 64'(LEVELS - 1);
    localparam logic [63:0] FULL = (64'd1 << PWM_BITS) - 64'd1;

    logic [rlf_pkg::PWM_W-1:0] w_lut [LEVELS];
    logic [IW-1:0]             w_idx;

    for (genvar gi = 0; gi < LEVELS; gi++) begin : g_ent
        localparam logic [63:0] V     = TOP - 64'(gi);
        localparam logic        LOW   = (64'd100 * V <= 64'd8 * TOP);
        localparam logic [63:0] B     = 64'd100 * V + 64'd16 * TOP;
        localparam logic [63:0] D     = 64'd116 * TOP;
        localparam logic [63:0] NUM   = LOW ? (64'd1000 * V * FULL) : (FULL * B * B * B);
        localparam logic [63:0] DEN   = LOW ? (64'd9023 * TOP) : (D * D * D);
        localparam logic [63:0] DUTY  = (64'd2 * NUM + DEN) / (64'd2 * DEN);
        assign w_lut[gi] = DUTY[rlf_pkg::PWM_W-1:0];
    end

    // clamp values past the table top
    always_comb begin
        if ({1'b0, i_c} > 9'(LEVELS - 1)) begin
            w_idx = IW'(LEVELS - 1);
        end else begin
            w_idx = i_c[IW-1:0];
        end
    end

    assign o_duty = w_lut[w_idx];

endmodule

### hdl/rlf_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlf_merge
// Output stage: collects the three lane colors and the busy flag into one
// result word and maps each color to its PWM duty.
// ----------------------------------------------------------------------------
module rlf_merge #(
    parameter int PWM_BITS = 10,
    parameter int LEVELS   = 256
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_load,
    input  logic [rlf_pkg::LANES-1:0][rlf_pkg::COL_W-1:0] i_shown,
    input  logic                                          i_busy,
    output logic                                          o_ready,
    rlf_out_if.source                                     o_out
);

    logic                                          r_valid;
    logic [rlf_pkg::LANES-1:0][rlf_pkg::COL_W-1:0] r_shown;
    logic                                          r_busy;
    logic [rlf_pkg::LANES-1:0][rlf_pkg::PWM_W-1:0] w_duty;

    // take a new word when empty or when the held word leaves
    assign o_ready = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_shown <= i_shown;
            r_busy  <= i_busy;
        end
    end

    for (genvar gl = 0; gl < rlf_pkg::LANES; gl++) begin : g_duty
        rlf_duty #(
            .PWM_BITS (PWM_BITS),
            .LEVELS   (LEVELS)
        ) u_duty (
            .i_c    (r_shown[gl]),
            .o_duty (w_duty[gl])
        );
    end

    assign o_out.valid       = r_valid;
    assign o_out.pwm_red     = w_duty[0];
    assign o_out.pwm_green   = w_duty[1];
    assign o_out.pwm_blue    = w_duty[2];
    assign o_out.shown_red   = r_shown[0];
    assign o_out.shown_green = r_shown[1];
    assign o_out.shown_blue  = r_shown[2];
    assign o_out.busy_res    = r_busy;

endmodule

### hdl/rgb_led_fade_flash_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_led_fade_flash_engine
// RGB LED driver with set, fade and flash commands, ticked stepping and
// inverted CIE lightness PWM duties.
//
//   channel  | dir | role
//   ---------+-----+-----------------------------------------------
//   i_in     | in  | command or tick word (cmd, color, count, pause)
//   o_out    | out | PWM duties, shown color and busy flag
//
// One word a cycle unless stalled: each word updates the state in the cycle
// it is accepted, its result in the output register from the next cycle on.
// The three color lanes step in parallel; the output stage merges them and
// looks up the duties in a constant table.
// A stalled output holds its word and drops i_in.ready only while full.
// Synchronous active-low reset clears the colors and returns to idle.
// ----------------------------------------------------------------------------
module rgb_led_fade_flash_engine #(
    parameter int PWM_BITS = 10,
    parameter int LEVELS   = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rlf_in_if.sink    i_in,
    rlf_out_if.source o_out
);

    rlf_pkg::t_act                                 r_act, n_act;
    logic [rlf_pkg::PAUSE_W-1:0]                   r_wait, n_wait;
    logic [rlf_pkg::PAUSE_W-1:0]                   r_pause, n_pause;
    logic [rlf_pkg::CNT_W-1:0]                     r_flashes, n_flashes;
    logic                                          r_phase, n_phase;

    rlf_pkg::t_lane_ctl                            w_ctl;
    logic                                          w_ready;
    logic                                          w_acc;
    logic [rlf_pkg::LANES-1:0][rlf_pkg::COL_W-1:0] w_col;
    logic [rlf_pkg::LANES-1:0][rlf_pkg::COL_W-1:0] w_shown_nx;
    logic [rlf_pkg::LANES-1:0]                     w_eq;
    logic                                          w_all_eq;

    assign i_in.ready = w_ready;
    assign w_acc      = i_in.valid && w_ready;
    assign w_col[0]   = i_in.red;
    assign w_col[1]   = i_in.green;
    assign w_col[2]   = i_in.blue;
    assign w_all_eq   = &w_eq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act     <= rlf_pkg::ACT_IDLE;
            r_wait    <= '0;
            r_pause   <= '0;
            r_flashes <= '0;
            r_phase   <= 1'b0;
        end else begin
            r_act     <= n_act;
            r_wait    <= n_wait;
            r_pause   <= n_pause;
            r_flashes <= n_flashes;
            r_phase   <= n_phase;
        end
    end

    always_comb begin
        n_act     = r_act;
        n_wait    = r_wait;
        n_pause   = r_pause;
        n_flashes = r_flashes;
        n_phase   = r_phase;
        w_ctl     = '{shown_src: rlf_pkg::SRC_KEEP, load_target: 1'b0,
                      save_shown: 1'b0, goal_col: 1'b0};
        if (w_acc) begin
            case (i_in.cmd)
                rlf_pkg::CMD_TICK: begin
                    if (r_act != rlf_pkg::ACT_IDLE) begin
                        if (r_wait != '0) begin
                            n_wait = r_wait - 1'b1;
                        end else if (r_act == rlf_pkg::ACT_FADE) begin
                            w_ctl.shown_src = rlf_pkg::SRC_STEP;
                            if (w_all_eq) begin
                                n_act = rlf_pkg::ACT_IDLE;
                            end else begin
                                n_wait = r_pause;
                            end
                        end else if (r_phase) begin
                            // back to the saved color: one flash done
                            w_ctl.shown_src = rlf_pkg::SRC_SAVED;
                            n_phase         = 1'b0;
                            if (r_flashes <= 8'd1) begin
                                n_flashes = '0;
                                n_act     = rlf_pkg::ACT_IDLE;
                            end else begin
                                n_flashes = r_flashes - 1'b1;
                                n_wait    = r_pause;
                            end
                        end else begin
                            w_ctl.shown_src = rlf_pkg::SRC_TARGET;
                            n_phase         = 1'b1;
                            n_wait          = r_pause;
                        end
                    end
                end
                rlf_pkg::CMD_SET: begin
                    w_ctl.shown_src = rlf_pkg::SRC_COL;
                    n_act           = rlf_pkg::ACT_IDLE;
                end
                rlf_pkg::CMD_RAMP: begin
                    // first step happens with the command
                    w_ctl.shown_src   = rlf_pkg::SRC_STEP;
                    w_ctl.load_target = 1'b1;
                    w_ctl.goal_col    = 1'b1;
                    n_pause           = i_in.pause_ticks;
                    n_wait            = i_in.pause_ticks;
                    n_act = w_all_eq ? rlf_pkg::ACT_IDLE : rlf_pkg::ACT_FADE;
                end
                rlf_pkg::CMD_BLINK: begin
                    n_act = rlf_pkg::ACT_IDLE;
                    if (i_in.flash_count != '0) begin
                        w_ctl.shown_src   = rlf_pkg::SRC_COL;
                        w_ctl.load_target = 1'b1;
                        w_ctl.save_shown  = 1'b1;
                        n_pause           = i_in.pause_ticks;
                        n_wait            = i_in.pause_ticks;
                        n_flashes         = i_in.flash_count;
                        n_phase           = 1'b1;
                        n_act             = rlf_pkg::ACT_FLASH;
                    end
                end
                default: begin
                    n_act = r_act;
                end
            endcase
        end
    end

    for (genvar gl = 0; gl < rlf_pkg::LANES; gl++) begin : g_lane
        rlf_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_col      (w_col[gl]),
            .o_shown_nx (w_shown_nx[gl]),
            .o_eq_step  (w_eq[gl])
        );
    end

    rlf_merge #(
        .PWM_BITS (PWM_BITS),
        .LEVELS   (LEVELS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_acc),
        .i_shown (w_shown_nx),
        .i_busy  (n_act != rlf_pkg::ACT_IDLE),
        .o_ready (w_ready),
        .o_out   (o_out)
    );

    a_acc_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> o_out.valid)
        else $error("accepted word produced no result");

    a_set_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in.cmd == rlf_pkg::CMD_SET) |=> !o_out.busy_res)
        else $error("set color left engine busy");

    a_wait_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_act != rlf_pkg::ACT_IDLE) |-> (r_wait <= r_pause))
        else $error("wait count above step pause");

    a_flash_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_act == rlf_pkg::ACT_FLASH) |-> (r_flashes != '0))
        else $error("flash running with no flashes left");

endmodule
